/* src/mcc_pkg.sv */
package mcc_pkg;

  localparam int CODE_W    = 32;
  localparam int NUM_PERM  = 24;
  localparam int NUM_CELLS = NUM_PERM - 1;  // identity is skipped
  localparam int PERM_W    = $clog2(NUM_PERM);
  localparam int TBL_CELLS = 16;

  // Permutations of {0,1,2,3} in lexicographic order; entry 0 is identity.
  localparam logic [1:0] PERM_TBL [NUM_PERM][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd3, 2'd2}, '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd0, 2'd2, 2'd3, 2'd1}, '{2'd0, 2'd3, 2'd1, 2'd2}, '{2'd0, 2'd3, 2'd2, 2'd1},
    '{2'd1, 2'd0, 2'd2, 2'd3}, '{2'd1, 2'd0, 2'd3, 2'd2}, '{2'd1, 2'd2, 2'd0, 2'd3},
    '{2'd1, 2'd2, 2'd3, 2'd0}, '{2'd1, 2'd3, 2'd0, 2'd2}, '{2'd1, 2'd3, 2'd2, 2'd0},
    '{2'd2, 2'd0, 2'd1, 2'd3}, '{2'd2, 2'd0, 2'd3, 2'd1}, '{2'd2, 2'd1, 2'd0, 2'd3},
    '{2'd2, 2'd1, 2'd3, 2'd0}, '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd2, 2'd3, 2'd1, 2'd0},
    '{2'd3, 2'd0, 2'd1, 2'd2}, '{2'd3, 2'd0, 2'd2, 2'd1}, '{2'd3, 2'd1, 2'd0, 2'd2},
    '{2'd3, 2'd1, 2'd2, 2'd0}, '{2'd3, 2'd2, 2'd0, 2'd1}, '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic              canon;
  } stage_t;

  // Relabel a table code under permutation k: U[p(a)][p(b)] = p(T[a][b]).
  // With k fixed per cell this is pure wiring.
  function automatic logic [CODE_W-1:0] relabel(input logic [PERM_W-1:0] k,
                                                input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] res;
    logic [3:0]        cidx;
    logic [1:0]        val;
    logic [3:0]        dst;
    res = '0;
    for (int c = 0; c < TBL_CELLS; c++) begin
      cidx = 4'(c);
      val  = code[2*c +: 2];
      dst  = {PERM_TBL[k][cidx[3:2]], PERM_TBL[k][cidx[1:0]]};
      res[{dst, 1'b0} +: 2] = PERM_TBL[k][val];
    end
    return res;
  endfunction

endpackage

/* src/mcc_if.sv */
interface mcc_in_if;
  logic                         valid;
  logic                         ready;
  logic [mcc_pkg::CODE_W-1:0]   table_code;

  modport source (output valid, output table_code, input ready);
  modport sink   (input valid, input table_code, output ready);
endinterface

interface mcc_out_if;
  logic                         valid;
  logic                         ready;
  logic [mcc_pkg::CODE_W-1:0]   code_echo;
  logic                         canonical;

  modport source (output valid, output code_echo, output canonical, input ready);
  modport sink   (input valid, input code_echo, input canonical, output ready);
endinterface

/* src/mcc_cell.sv */
// One permutation test: relabels the code, clears the flag on a smaller
// result and hands the item to the next cell.
module mcc_cell #(
  parameter int PERM_IDX = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  mcc_pkg::stage_t stg_in,
  output mcc_pkg::stage_t stg_out
);

  localparam logic [mcc_pkg::PERM_W-1:0] K = mcc_pkg::PERM_W'(PERM_IDX);

  logic [mcc_pkg::CODE_W-1:0] relab;
  logic                       valid_r;
  logic [mcc_pkg::CODE_W-1:0] code_r;
  logic                       canon_r;
  logic                       canon_nxt;

  assign relab     = mcc_pkg::relabel(K, stg_in.code);
  assign canon_nxt = stg_in.canon & ~(relab < stg_in.code);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= stg_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      code_r  <= stg_in.code;
      canon_r <= canon_nxt;
    end
  end

  assign stg_out = '{valid: valid_r, code: code_r, canon: canon_r};

endmodule

/* src/magma4_canonical_check_unit.sv */
// Canonical-form check for a 4-element operation table.
// in_chan carries table_code (sixteen 2-bit cells, cell 4*row+col at bit
// 2*cell). out_chan returns code_echo (the same code) and canonical, which is
// 1 when none of the 23 non-identity relabelings gives a smaller code.
// Both channels use valid/ready; an item moves when both are high.
// The check runs down a row of 23 cells, one permutation per cell; the item
// advances one cell per cycle unless the row is held. Throughput is one item
// per cycle unless the receiver stalls: the cells all hold items at once and
// the last cell's register drives out_chan directly.
// When the receiver stalls with a result waiting, the whole row holds and
// in_chan.ready drops; bubbles still move forward while the last cell is empty.
// Reset empties every cell; no result is pending after reset, and the block
// has no other state.
module magma4_canonical_check_unit (
  input  logic        clk,
  input  logic        rst_n,
  mcc_in_if.sink      in_chan,
  mcc_out_if.source   out_chan
);

  mcc_pkg::stage_t stg [mcc_pkg::NUM_CELLS+1];
  logic            adv;

  assign adv           = ~stg[mcc_pkg::NUM_CELLS].valid | out_chan.ready;
  assign in_chan.ready = adv;

  assign stg[0] = '{valid: in_chan.valid, code: in_chan.table_code, canon: 1'b1};

  for (genvar g = 0; g < mcc_pkg::NUM_CELLS; g++) begin : g_cell
    mcc_cell #(
      .PERM_IDX (g + 1)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .stg_in  (stg[g]),
      .stg_out (stg[g+1])
    );
  end

  assign out_chan.valid     = stg[mcc_pkg::NUM_CELLS].valid;
  assign out_chan.code_echo = stg[mcc_pkg::NUM_CELLS].code;
  assign out_chan.canonical = stg[mcc_pkg::NUM_CELLS].canon;

endmodule

/* dv/magma4_canonical_check_unit_test.sv */
module magma4_canonical_check_unit_test;

  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 750;

  typedef logic [mcc_pkg::CODE_W-1:0] code_t;

  typedef struct {
    code_t code;
    logic  canon;
  } verdict_t;

  typedef enum int {TK_ADD, TK_XOR, TK_LEFT, TK_RIGHT, TK_MIN, TK_MAX} table_kind_t;

  class canon_tracker;
    logic [1:0] perms[24][4];
    verdict_t   expected_verdicts[$];
    int         mismatches;

    function new();
      int n;
      n = 0;
      mismatches = 0;
      for (int a = 0; a < 4; a++)
        for (int b = 0; b < 4; b++)
          for (int c = 0; c < 4; c++)
            for (int d = 0; d < 4; d++)
              if (a != b && a != c && a != d && b != c && b != d && c != d) begin
                perms[n][0] = 2'(a);
                perms[n][1] = 2'(b);
                perms[n][2] = 2'(c);
                perms[n][3] = 2'(d);
                n++;
              end
    endfunction

    // U[p(a)][p(b)] = p(T[a][b])
    function code_t relabel_code(int k, code_t code);
      code_t      res;
      logic [1:0] val;
      int         dst;
      res = '0;
      for (int slot = 0; slot < 16; slot++) begin
        val = code[2*slot +: 2];
        dst = 4 * perms[k][slot / 4] + perms[k][slot % 4];
        res[2*dst +: 2] = perms[k][val];
      end
      return res;
    endfunction

    // identity is in the list too; it only ever gives an equal code
    function logic predict_canonical(code_t code);
      logic canon;
      canon = 1'b1;
      for (int k = 0; k < 24; k++)
        if (relabel_code(k, code) < code) canon = 1'b0;
      return canon;
    endfunction

    function void note_table(code_t code);
      verdict_t v;
      v.code  = code;
      v.canon = predict_canonical(code);
      expected_verdicts = {expected_verdicts, v};
    endfunction

    function void check_verdict(code_t code, logic canon);
      verdict_t v;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result code_echo=%h canonical=%b", $time, code, canon);
        mismatches++;
        return;
      end
      v = expected_verdicts.pop_front();
      if (code !== v.code) begin
        $display("%0t: code_echo expected %h actual %h", $time, v.code, code);
        mismatches++;
      end
      if (canon !== v.canon) begin
        $display("%0t: canonical for %h expected %b actual %b", $time, v.code, v.canon,
                 canon);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   quiet_cycles;

  canon_tracker tracker;

  mcc_in_if  in_bus ();
  mcc_out_if out_bus ();

  magma4_canonical_check_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.table_code = '0;
    out_bus.ready = 1'b0;
    src_idle_pct = 35;
    sink_idle_pct = 35;
    quiet_cycles = 0;
    tracker = new();
  end

  always #2 clk = ~clk;

  // result side: check on acceptance, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready)
        tracker.check_verdict(out_bus.code_echo, out_bus.canonical);
      out_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("magma4_canonical_check_unit_test: FAIL");
      $finish;
    end
  end

  task automatic send_table(input code_t code);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.table_code <= code;
    tracker.note_table(code);
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic drive_directed();
    code_t       code;
    table_kind_t kind;
    int          v;
    send_table(32'h0000_0000);
    send_table(32'hffff_ffff);
    send_table(32'h5555_5555);
    send_table(32'haaaa_aaaa);
    send_table(32'h0000_ffff);
    send_table(32'hffff_0000);
    send_table(32'h0000_0001);
    send_table(32'h8000_0000);
    send_table(32'h0001_0000);
    send_table(32'h1234_5678);
    send_table(32'hfedc_ba98);
    // structured tables; left and right projections are fixed by every
    // relabeling, so their relabeled codes equal the input
    kind = TK_ADD;
    do begin
      for (int a = 0; a < 4; a++)
        for (int b = 0; b < 4; b++) begin
          case (kind)
            TK_ADD:   v = (a + b) % 4;
            TK_XOR:   v = a ^ b;
            TK_LEFT:  v = a;
            TK_RIGHT: v = b;
            TK_MIN:   v = (a < b) ? a : b;
            default:  v = (a > b) ? a : b;
          endcase
          code[2*(4*a+b) +: 2] = 2'(v);
        end
      send_table(code);
      // same table relabeled by a random permutation
      send_table(tracker.relabel_code($urandom_range(1, 23), code));
      kind = kind.next();
    end while (kind != TK_ADD);
  endtask

  task automatic drive_random();
    code_t code;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end else if (i == 450) begin
        src_idle_pct = 35;
        sink_idle_pct = 35;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: code = $urandom();
        5, 6: begin
          // entries limited to 0/1 - small orbits, more ties
          for (int slot = 0; slot < 16; slot++)
            code[2*slot +: 2] = 2'($urandom_range(0, 1));
        end
        7: code = $urandom_range(0, 65535);
        8: code = $urandom() & $urandom() & $urandom();
        default: begin
          // a relabeled copy of a random table
          code = tracker.relabel_code($urandom_range(0, 23), $urandom());
        end
      endcase
      send_table(code);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    drive_directed();
    drive_random();
    in_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("magma4_canonical_check_unit_test: PASS");
    end else begin
      $display("magma4_canonical_check_unit_test: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/mcc_pkg.sv
src/mcc_if.sv
src/mcc_cell.sv
src/magma4_canonical_check_unit.sv
dv/magma4_canonical_check_unit_test.sv
